@@ design/ttbp_pkg.sv @@
// Shared types and constants for the triple token bucket policer.
package ttbp_pkg;

  localparam int unsigned FLOW_ENTRIES = 1024;
  localparam int unsigned ENTRY_AW     = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam logic [63:0] NS_PER_SEC   = 64'd1000000000;
  localparam logic [29:0] NS_PER_SEC_30 = 30'd1000000000;
  // floor(2^61 / 1e9)
  localparam logic [31:0] RECIP_NS     = 32'd2305843009;
  localparam logic [7:0]  FLAG_SYN     = 8'h02;
  localparam logic [7:0]  FLAG_ACK     = 8'h10;

  typedef enum logic [2:0] {
    CFG_PACKET_RATE = 3'd0,
    CFG_BIT_RATE    = 3'd1,
    CFG_SYN_RATE    = 3'd2,
    CFG_PKT_BURST   = 3'd3,
    CFG_BYT_BURST   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_EST,
    ST_DIV,
    ST_UPD
  } state_t;

  // one table entry, packed for a memory with one read and one write port
  typedef struct packed {
    logic [63:0] last_time;
    logic [31:0] pkt_tok;
    logic [31:0] byte_tok;
    logic [31:0] syn_tok;
    logic [47:0] pkt_cnt;
    logic [63:0] byte_cnt;
    logic [47:0] syn_cnt;
  } entry_t;

  typedef struct packed {
    logic [31:0] packet_rate;
    logic [31:0] bit_rate;
    logic [31:0] syn_rate;
    logic [31:0] pkt_burst;
    logic [31:0] byt_burst;
  } cfg_t;

endpackage

@@ design/ttbp_table.sv @@
// Flow entry table: entry memory plus a valid-flag memory cleared by a pass after reset.
module ttbp_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [ttbp_pkg::ENTRY_AW-1:0] rd_addr,
  output ttbp_pkg::entry_t              rd_data,
  output logic                          rd_valid,
  input  logic                          wr_en,
  input  logic [ttbp_pkg::ENTRY_AW-1:0] wr_addr,
  input  ttbp_pkg::entry_t              wr_data,
  output logic                          clearing
);
  import ttbp_pkg::*;

  entry_t mem [FLOW_ENTRIES];
  logic   valid_mem [FLOW_ENTRIES];
  logic   clr_r;
  logic [ENTRY_AW-1:0] clr_addr_r;

  assign clearing = clr_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (clr_r)      valid_mem[clr_addr_r] <= 1'b0;
    else if (wr_en) valid_mem[wr_addr] <= 1'b1;
    if (rd_en) rd_valid <= valid_mem[rd_addr];
  end

  // one entry per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ENTRY_AW'(FLOW_ENTRIES - 1)) clr_r <= 1'b0;
    end
  end

endmodule

@@ design/ttbp_refill.sv @@
// Refill arithmetic: three rate multiplies, reciprocal estimate of /1e9, then fix-up.
module ttbp_refill (
  input  logic        clk,
  input  logic        mul_en,
  input  logic        est_en,
  input  logic        div_en,
  input  logic [29:0] elapsed,
  input  ttbp_pkg::cfg_t cfg,
  output logic [33:0] pkt_add,
  output logic [31:0] byte_add,
  output logic [33:0] syn_add
);
  import ttbp_pkg::*;

  // elapsed <= 1e9 < 2^30, so products fit in 62 bits
  logic [61:0] pkt_prod_r, bit_prod_r, syn_prod_r;
  logic [31:0] pkt_est_r, bit_est_r, syn_est_r;
  logic [33:0] bit_q;

  // low by at most four
  function automatic logic [31:0] quot_est(logic [61:0] prod);
    logic [63:0] m;
    m = {32'd0, prod[61:30]} * {32'd0, RECIP_NS};
    return m[62:31];
  endfunction

  function automatic logic [33:0] quot_fix(logic [61:0] prod, logic [31:0] est);
    logic [61:0] back;
    logic [61:0] rem;
    logic [2:0]  adj;
    back = {30'd0, est} * {32'd0, NS_PER_SEC_30};
    rem  = prod - back;
    adj  = {2'd0, (rem >= 62'(NS_PER_SEC))}
         + {2'd0, (rem >= 62'(NS_PER_SEC * 64'd2))}
         + {2'd0, (rem >= 62'(NS_PER_SEC * 64'd3))}
         + {2'd0, (rem >= 62'(NS_PER_SEC * 64'd4))};
    return {2'd0, est} + {31'd0, adj};
  endfunction

  always_ff @(posedge clk) begin
    if (mul_en) begin
      pkt_prod_r <= {32'd0, elapsed} * {30'd0, cfg.packet_rate};
      bit_prod_r <= {32'd0, elapsed} * {30'd0, cfg.bit_rate};
      syn_prod_r <= {32'd0, elapsed} * {30'd0, cfg.syn_rate};
    end
  end

  always_ff @(posedge clk) begin
    if (est_en) begin
      pkt_est_r <= quot_est(pkt_prod_r);
      bit_est_r <= quot_est(bit_prod_r);
      syn_est_r <= quot_est(syn_prod_r);
    end
  end

  // bits per ns quotient fits 32 bits; /8 for bytes is a shift
  assign bit_q = quot_fix(bit_prod_r, bit_est_r);

  always_ff @(posedge clk) begin
    if (div_en) begin
      pkt_add  <= quot_fix(pkt_prod_r, pkt_est_r);
      byte_add <= {3'd0, bit_q[31:3]};
      syn_add  <= quot_fix(syn_prod_r, syn_est_r);
    end
  end

endmodule

@@ design/triple_token_bucket_policer.sv @@
// Top level of the triple token bucket policer.
//  channel | ports                 | handshake
//  input   | in_*                  | start & !busy
//  result  | out_*                 | out_valid strobe, one cycle
//  config  | cfg_*                 | cfg_valid & cfg_ready
// A request passes through table read, rate multiply, reciprocal estimate,
// quotient fix-up, update and write back, then the result strobe.
// busy stays high from the table read through the update; a new request can be taken
// in the strobe cycle, so requests do not overlap in the table read-modify-write.
// After reset busy stays high while the valid flags are cleared.
// Results cannot stall.
module triple_token_bucket_policer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  in_flow_index,
  input  logic [63:0] in_now_ns,
  input  logic [15:0] in_pkt_len,
  input  logic        in_is_tcp,
  input  logic [7:0]  in_tcp_flags,
  output logic        out_valid,
  output logic [9:0]  out_flow_echo,
  output logic        out_exceeded,
  output logic [47:0] out_packets_total,
  output logic [63:0] out_bytes_total,
  output logic [47:0] out_syns_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ttbp_pkg::*;

  state_t state_r, state_nxt;
  cfg_t   cfg_r;

  logic [9:0]  flow_r;
  logic [63:0] now_r;
  logic [15:0] len_r;
  logic        syn_r;

  entry_t rd_data, cur_r, wr_data;
  logic   rd_valid;
  logic   clearing;
  logic [29:0] elapsed_r;
  logic [31:0] pkt_burst_r, syn_burst_r, byt_burst_r;
  logic [33:0] pkt_add, syn_add;
  logic [31:0] byte_add;
  logic rd_en, mul_en, est_en, div_en, wr_en;
  logic [ENTRY_AW-1:0] addr, addr_r;

  assign addr      = ENTRY_AW'(in_flow_index % FLOW_ENTRIES);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PACKET_RATE: cfg_r.packet_rate <= cfg_data;
        CFG_BIT_RATE:    cfg_r.bit_rate    <= cfg_data;
        CFG_SYN_RATE:    cfg_r.syn_rate    <= cfg_data;
        CFG_PKT_BURST:   cfg_r.pkt_burst   <= cfg_data;
        CFG_BYT_BURST:   cfg_r.byt_burst   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start && !clearing) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_EST;
      ST_EST:  state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en  = (state_r == ST_IDLE) && start && !clearing;
    mul_en = (state_r == ST_MUL);
    est_en = (state_r == ST_EST);
    div_en = (state_r == ST_DIV);
    wr_en  = (state_r == ST_UPD);
    busy   = (state_r != ST_IDLE) || clearing;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  ttbp_table u_table (
    .clk, .rst_n, .rd_en, .rd_addr(addr), .rd_data, .rd_valid,
    .wr_en, .wr_addr(addr_r), .wr_data, .clearing
  );

  // capture request
  always_ff @(posedge clk) begin
    if (rd_en) begin
      flow_r <= in_flow_index;
      addr_r <= addr;
      now_r  <= in_now_ns;
      len_r  <= in_pkt_len;
      syn_r  <= in_is_tcp && ((in_tcp_flags & FLAG_SYN) != 8'd0)
                && ((in_tcp_flags & FLAG_ACK) == 8'd0);
    end
  end

  // bursts and entry fix-up once the read returns
  logic [31:0] pb, sb, bb;
  logic [63:0] el;
  entry_t fresh;
  always_comb begin
    pb = (cfg_r.pkt_burst != 0) ? cfg_r.pkt_burst :
         (cfg_r.packet_rate != 0) ? cfg_r.packet_rate : 32'd1;
    sb = (cfg_r.pkt_burst != 0) ? cfg_r.pkt_burst :
         (cfg_r.syn_rate != 0) ? cfg_r.syn_rate : 32'd1;
    bb = (cfg_r.byt_burst != 0) ? cfg_r.byt_burst :
         (cfg_r.bit_rate[31:3] != 0) ? {3'd0, cfg_r.bit_rate[31:3]} :
         (len_r != 0) ? {16'd0, len_r} : 32'd1;
    fresh = rd_data;
    if (!rd_valid) begin
      fresh.last_time = now_r;
      fresh.pkt_tok   = pb;
      fresh.byte_tok  = bb;
      fresh.syn_tok   = sb;
      fresh.pkt_cnt   = '0;
      fresh.byte_cnt  = '0;
      fresh.syn_cnt   = '0;
    end
    el = now_r - fresh.last_time;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      cur_r       <= fresh;
      pkt_burst_r <= pb;
      syn_burst_r <= sb;
      byt_burst_r <= bb;
      elapsed_r   <= (el > NS_PER_SEC) ? 30'(NS_PER_SEC) : el[29:0];
    end
  end

  ttbp_refill u_refill (
    .clk, .mul_en, .est_en, .div_en, .elapsed(elapsed_r), .cfg(cfg_r),
    .pkt_add, .byte_add, .syn_add
  );

  logic [31:0] pt, bt, st;
  logic [33:0] ps, ss;
  logic [32:0] bs;
  logic over;
  always_comb begin
    pt = cur_r.pkt_tok;
    bt = cur_r.byte_tok;
    st = cur_r.syn_tok;
    ps = {2'd0, pt} + pkt_add;
    bs = {1'b0, bt} + {1'b0, byte_add};
    ss = {2'd0, st} + syn_add;
    wr_data = cur_r;
    if (elapsed_r != 0) begin
      if (cfg_r.packet_rate != 0) pt = (ps < {2'd0, pkt_burst_r}) ? ps[31:0] : pkt_burst_r;
      if (cfg_r.bit_rate != 0)    bt = (bs < {1'b0, byt_burst_r}) ? bs[31:0] : byt_burst_r;
      if (cfg_r.syn_rate != 0)    st = (ss < {2'd0, syn_burst_r}) ? ss[31:0] : syn_burst_r;
      wr_data.last_time = now_r;
    end
    over = ((cfg_r.packet_rate != 0) && (pt == 0))
        || ((cfg_r.bit_rate != 0) && (bt < {16'd0, len_r}))
        || ((cfg_r.syn_rate != 0) && syn_r && (st == 0));
    if (!over) begin
      if (cfg_r.packet_rate != 0)        pt = pt - 32'd1;
      if (cfg_r.bit_rate != 0)           bt = bt - {16'd0, len_r};
      if ((cfg_r.syn_rate != 0) && syn_r) st = st - 32'd1;
    end
    wr_data.pkt_tok  = pt;
    wr_data.byte_tok = bt;
    wr_data.syn_tok  = st;
    wr_data.pkt_cnt  = cur_r.pkt_cnt + 48'd1;
    wr_data.byte_cnt = cur_r.byte_cnt + {48'd0, len_r};
    wr_data.syn_cnt  = cur_r.syn_cnt + {47'd0, syn_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= wr_en;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_flow_echo     <= flow_r;
      out_exceeded      <= over;
      out_packets_total <= wr_data.pkt_cnt;
      out_bytes_total   <= wr_data.byte_cnt;
      out_syns_total    <= wr_data.syn_cnt;
    end
  end

endmodule

@@ design/ttbp_checker.sv @@
// Port-level checker for the policer, bound to the top level.
module ttbp_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_ready
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request not taken");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##4 !out_valid ##1 out_valid) else $error("result late");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy with result");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready) else $error("cfg stalled");

endmodule

bind triple_token_bucket_policer ttbp_checker u_ttbp_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .cfg_ready
);
